// File: rtl/nat_connection_table_top_macros.svh
// Assertion macros shared by the connection table RTL.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef NAT_CONNECTION_TABLE_TOP_MACROS_SVH
`define NAT_CONNECTION_TABLE_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define NCT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nct check failed");
// Next-cycle implication checked outside reset.
`define NCT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nct check failed");
`endif

// File: rtl/nct_pkg.sv
// Package for the connection table: payload structs, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nct_pkg;
   localparam int unsigned TableEntries = 32;
   localparam logic [15:0] EthIpv4      = 16'h0800;
   localparam logic [31:0] IpBcast      = 32'hFFFF_FFFF;
   localparam logic [7:0]  ProtoTcp     = 8'd6;
   localparam logic [7:0]  ProtoUdp     = 8'd17;
   localparam logic [7:0]  ProtoIcmp    = 8'd1;
   localparam logic [31:0] RstLocalIp   = 32'h0;
   localparam logic [31:0] RstNetMask   = 32'hFFFF_FF00;
   localparam logic [15:0] RstDivert    = 16'd1234;

   typedef enum logic [1:0] {
      CMD_OUTBOUND = 2'd0,
      CMD_INBOUND  = 2'd1,
      CMD_PIN      = 2'd2,
      CMD_UNPIN    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_LOCAL_IP    = 2'd0,
      REG_NET_MASK    = 2'd1,
      REG_DIVERT_PORT = 2'd2
   } reg_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_DONE = 2'd2,
      ST_OUT  = 2'd3
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] ether_type;
      logic [7:0]  ip_proto;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_l4_port;
      logic [15:0] dst_l4_port;
      logic [31:0] now_tick;
      logic [4:0]  entry_sel;
   } req_type;

   typedef struct packed {
      logic        verdict;
      logic [31:0] new_ip;
      logic [15:0] new_port;
      logic [4:0]  entry_index;
   } rsp_type;

   // One table entry as it circulates round the ring.
   typedef struct packed {
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_l4_port;
      logic [15:0] dst_l4_port;
      logic [7:0]  proto;
      logic [31:0] last_used;
      logic        pinned;
   } entry_type;

   // Control from the sequencer to every cell.
   typedef struct packed {
      logic        shift;
      logic        wr_hit;
      logic        wr_full;
      logic        set_pin;
      logic        clr_pin;
      entry_type   wdata;
   } cell_ctl_type;
endpackage
`default_nettype wire

// File: rtl/nct_cell.sv
// One entry cell of the rotating table ring.
// Depends on nct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nct_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire nct_pkg::cell_ctl_type ctl,
   input  wire logic                  at_head,
   input  wire nct_pkg::entry_type    from_prev,
   output nct_pkg::entry_type         entry
);
   nct_pkg::entry_type entry_ff, entry_in;

   // Rotate on shift; the head cell takes writes.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift) begin
         entry_in = from_prev;
      end else if (at_head) begin
         if (ctl.wr_full) begin
            entry_in = ctl.wdata;
            entry_in.pinned = entry_ff.pinned;
         end else if (ctl.wr_hit) begin
            entry_in.last_used = ctl.wdata.last_used;
         end
         if (ctl.set_pin) entry_in.pinned = 1'b1;
         if (ctl.clr_pin) entry_in.pinned = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;
endmodule
`default_nettype wire

// File: rtl/nct_seq.sv
// Sequencer: compares the head cell each rotation, picks hit and victim,
// then rotates the chosen entry to the head for update. Depends on nct_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "nat_connection_table_top_macros.svh"
module nct_seq #(
   parameter int unsigned ENTRIES = nct_pkg::TableEntries,
   localparam int unsigned IW = $clog2(ENTRIES),
   localparam int unsigned CW = $clog2(ENTRIES + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire nct_pkg::req_type      req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output nct_pkg::rsp_type           rsp_data,
   input  wire logic [31:0]           local_ip,
   input  wire logic [31:0]           net_mask,
   input  wire logic [15:0]           divert_port,
   input  wire nct_pkg::entry_type    head,
   output nct_pkg::cell_ctl_type      ctl
);
   nct_pkg::state_type st_ff, st_in;
   nct_pkg::req_type   req_ff, req_in;
   logic [CW-1:0]      cnt_ff, cnt_in;   // rotation count
   logic [IW-1:0]      pos_ff, pos_in;   // index now at head
   logic               hit_ff, hit_in;
   logic [IW-1:0]      hidx_ff, hidx_in;
   logic [IW-1:0]      vidx_ff, vidx_in;
   logic [31:0]        best_ff, best_in;
   logic               gate_ff, gate_in;
   nct_pkg::rsp_type   res_ff, res_in;   // finished result awaiting the output
   nct_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rv_ff, rv_in;

   logic        m_out, m_src, ok_out, ok_in, tgt_hit;
   logic [31:0] age;
   logic [IW-1:0] tgt;
   nct_pkg::cmd_type cmd;

   assign cmd = nct_pkg::cmd_type'(req_ff.command);
   assign age = req_ff.now_tick - head.last_used;
   assign m_out = head.src_ip == req_ff.src_ip && head.dst_ip == req_ff.dst_ip
                  && head.src_l4_port == req_ff.src_l4_port
                  && head.dst_l4_port == req_ff.dst_l4_port
                  && head.proto == req_ff.ip_proto;
   // Inbound looks up by destination, pin by source.
   assign m_src = (cmd == nct_pkg::CMD_INBOUND)
      ? (head.src_ip == req_ff.dst_ip && head.src_l4_port == req_ff.dst_l4_port
         && head.proto == req_ff.ip_proto)
      : (head.src_ip == req_ff.src_ip && head.src_l4_port == req_ff.src_l4_port
         && head.proto == req_ff.ip_proto);
   assign ok_out = req_data.ether_type == nct_pkg::EthIpv4 && req_data.dst_ip != nct_pkg::IpBcast
      && (local_ip & net_mask) != (req_data.dst_ip & net_mask)
      && (req_data.ip_proto == nct_pkg::ProtoTcp || req_data.ip_proto == nct_pkg::ProtoUdp);
   assign ok_in = req_data.ether_type == nct_pkg::EthIpv4
      && (req_data.src_ip == local_ip || req_data.src_l4_port == divert_port)
      && (req_data.ip_proto == nct_pkg::ProtoTcp || req_data.ip_proto == nct_pkg::ProtoUdp
          || req_data.ip_proto == nct_pkg::ProtoIcmp);
   assign tgt = hit_ff ? hidx_ff : vidx_ff;
   assign tgt_hit = hit_ff;

   // Next state and datapath control.
   always_comb begin
      st_in = st_ff; req_in = req_ff; cnt_in = cnt_ff; pos_in = pos_ff;
      hit_in = hit_ff; hidx_in = hidx_ff; vidx_in = vidx_ff; best_in = best_ff;
      gate_in = gate_ff; res_in = res_ff; rsp_in = rsp_ff; rv_in = rv_ff;
      ctl = '0;
      ctl.wdata.src_ip = req_ff.src_ip;
      ctl.wdata.dst_ip = req_ff.dst_ip;
      ctl.wdata.src_l4_port = req_ff.src_l4_port;
      ctl.wdata.dst_l4_port = req_ff.dst_l4_port;
      ctl.wdata.proto = req_ff.ip_proto;
      ctl.wdata.last_used = req_ff.now_tick;
      req_ready = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (st_ff)
         nct_pkg::ST_IDLE: begin
            // Rotate entry 0 back to the head before taking a transaction.
            if (pos_ff != '0) begin
               ctl.shift = 1'b1;
               pos_in = (pos_ff == IW'(ENTRIES - 1)) ? '0 : pos_ff + 1'b1;
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  req_in = req_data;
                  cnt_in = '0; hit_in = 1'b0; hidx_in = '0; vidx_in = '0; best_in = '0;
                  case (nct_pkg::cmd_type'(req_data.command))
                     nct_pkg::CMD_OUTBOUND: gate_in = ok_out;
                     nct_pkg::CMD_INBOUND:  gate_in = ok_in;
                     nct_pkg::CMD_PIN:      gate_in = 1'b1;
                     default: gate_in = 32'(req_data.entry_sel) < ENTRIES;
                  endcase
                  st_in = nct_pkg::ST_SCAN;
               end
            end
         end
         nct_pkg::ST_SCAN: begin
            // Compare head, then rotate one place.
            if (gate_ff && !hit_ff) begin
               if (cmd == nct_pkg::CMD_OUTBOUND && m_out) begin
                  hit_in = 1'b1; hidx_in = pos_ff;
               end else if (cmd != nct_pkg::CMD_OUTBOUND && m_src) begin
                  hit_in = 1'b1; hidx_in = pos_ff;
               end
            end
            if (!head.pinned && age > best_ff) begin
               best_in = age; vidx_in = pos_ff;
            end
            if (cmd == nct_pkg::CMD_UNPIN)
               hit_in = 1'b1;
            if (cmd == nct_pkg::CMD_UNPIN)
               hidx_in = IW'(req_ff.entry_sel);
            ctl.shift = 1'b1;
            pos_in = (pos_ff == IW'(ENTRIES - 1)) ? '0 : pos_ff + 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(ENTRIES - 1)) begin
               cnt_in = '0;
               st_in = nct_pkg::ST_DONE;
               if (!gate_ff || (cmd != nct_pkg::CMD_OUTBOUND && !hit_in)) begin
                  res_in = '0; res_in.verdict = 1'b1;
                  st_in = nct_pkg::ST_OUT;
               end
            end
         end
         nct_pkg::ST_DONE: begin
            // Rotate the target to the head, then update it.
            if (pos_ff != tgt) begin
               ctl.shift = 1'b1;
               pos_in = (pos_ff == IW'(ENTRIES - 1)) ? '0 : pos_ff + 1'b1;
            end else begin
               res_in = '0;
               res_in.entry_index = 5'(tgt);
               case (cmd)
                  nct_pkg::CMD_OUTBOUND: begin
                     ctl.wr_hit = tgt_hit; ctl.wr_full = !tgt_hit;
                     res_in.new_ip = local_ip; res_in.new_port = divert_port;
                  end
                  nct_pkg::CMD_INBOUND: begin
                     res_in.new_ip = head.dst_ip; res_in.new_port = head.dst_l4_port;
                  end
                  nct_pkg::CMD_PIN: begin
                     ctl.set_pin = 1'b1;
                     res_in.new_ip = head.dst_ip; res_in.new_port = head.dst_l4_port;
                  end
                  default: ctl.clr_pin = 1'b1;
               endcase
               st_in = nct_pkg::ST_OUT;
            end
         end
         default: begin
            // Hold until the output register is free, then load it.
            if (!rv_ff || rsp_ready) begin
               rsp_in = res_ff;
               rv_in = 1'b1;
               st_in = nct_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= nct_pkg::ST_IDLE;
         pos_ff <= '0;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
         hit_ff <= 1'b0;
         gate_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
         rv_ff <= rv_in;
         hit_ff <= hit_in;
         gate_ff <= gate_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      hidx_ff <= hidx_in;
      vidx_ff <= vidx_in;
      best_ff <= best_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;

   `NCT_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, st_ff == nct_pkg::ST_IDLE)
   `NCT_ASSERT_IMP(a_scan_bound, clock, reset, st_ff == nct_pkg::ST_SCAN,
                   cnt_ff < CW'(ENTRIES))
   `NCT_ASSERT_NXT(a_accept_scan, clock, reset, req_valid && req_ready,
                   st_ff == nct_pkg::ST_SCAN)
   `NCT_ASSERT_NXT(a_ring_home, clock, reset,
                   st_ff == nct_pkg::ST_SCAN && cnt_ff == CW'(ENTRIES - 1), pos_ff == '0)
endmodule
`default_nettype wire

// File: rtl/nat_connection_table_top.sv
// Connection table top level: configuration registers, cell ring, sequencer.
// Depends on nct_pkg, nct_cell and nct_seq.
//
// Usage: a request transaction on req_valid/req_ready carries one packet
// header and a command; one response transaction on rsp_valid/rsp_ready
// follows for every request. Registers local_ip (0), net_mask (1) and
// divert_port (2) are written through csr_write_en/csr_index/csr_wdata.
// The table is a ring of TABLE_ENTRIES cells, rotated once per cycle while
// the sequencer shifts it; each request makes one full rotation comparing
// the head cell, then rotates the chosen entry to the head for update, and
// the ring turns on back to entry 0 before the next request is taken. One
// request is in flight at a time.
// Reset clears every entry and loads the register reset values at once.
// A stalled receiver holds the response in the output register; the block
// then finishes at most the next request into a holding register and waits.
`timescale 1ns / 1ps
`default_nettype none
module nat_connection_table_top #(
   parameter int unsigned TABLE_ENTRIES = nct_pkg::TableEntries
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire nct_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output nct_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write_en,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_wdata
);
   logic [31:0] local_ip_ff, net_mask_ff;
   logic [15:0] divert_ff;
   nct_pkg::cell_ctl_type ctl;
   nct_pkg::entry_type    ring [TABLE_ENTRIES];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff <= nct_pkg::RstLocalIp;
         net_mask_ff <= nct_pkg::RstNetMask;
         divert_ff <= nct_pkg::RstDivert;
      end else if (csr_write_en) begin
         case (nct_pkg::reg_type'(csr_index))
            nct_pkg::REG_LOCAL_IP:    local_ip_ff <= csr_wdata;
            nct_pkg::REG_NET_MASK:    net_mask_ff <= csr_wdata;
            nct_pkg::REG_DIVERT_PORT: divert_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Ring: cell k takes from cell k+1, so cell 0 sees entries in index order.
   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      nct_cell u_cell (
         .clock(clock), .reset(reset), .ctl(ctl), .at_head(k == 0),
         .from_prev(ring[(k + 1) % TABLE_ENTRIES]), .entry(ring[k])
      );
   end

   nct_seq #(.ENTRIES(TABLE_ENTRIES)) u_seq (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .local_ip(local_ip_ff), .net_mask(net_mask_ff), .divert_port(divert_ff),
      .head(ring[0]), .ctl(ctl)
   );
endmodule
`default_nettype wire

// File: tb/sv/nat_connection_table_top_test.sv
// Self-checking testbench for the NAT connection table: directed and random
// packet headers against a behavioural table model. Depends on nct_pkg.
`timescale 1ns / 1ps
module nat_connection_table_top_test;
   localparam int Entries = 32;
   localparam int StallLimit = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   nct_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   nct_pkg::rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   nat_connection_table_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Model state of the table and its registers
   logic [31:0] mdl_local_ip;
   logic [31:0] mdl_net_mask;
   logic [15:0] mdl_divert;
   logic [31:0] tab_sip [Entries];
   logic [31:0] tab_dip [Entries];
   logic [15:0] tab_sport [Entries];
   logic [15:0] tab_dport [Entries];
   logic [7:0]  tab_proto [Entries];
   logic [31:0] tab_used [Entries];
   logic        tab_pin [Entries];

   nct_pkg::rsp_type pending_rsp [$];
   int errors = 0;
   int idle_cycles = 0;

   // Keep a pool of flows seen so that later items hit the table
   nct_pkg::req_type flow_pool [$];

   function automatic int find_src(logic [31:0] ip, logic [15:0] port, logic [7:0] pr);
      for (int i = 0; i < Entries; i++)
         if (tab_sip[i] == ip && tab_sport[i] == port && tab_proto[i] == pr) return i;
      return -1;
   endfunction

   // Work out the response to one request and update the model table
   function automatic nct_pkg::rsp_type predict_translation(nct_pkg::req_type r);
      nct_pkg::rsp_type o;
      int hit;
      logic [31:0] best, age;
      o = '{verdict: 1'b1, new_ip: '0, new_port: '0, entry_index: '0};
      case (nct_pkg::cmd_type'(r.command))
         nct_pkg::CMD_OUTBOUND: begin
            if (r.ether_type != nct_pkg::EthIpv4 || r.dst_ip == nct_pkg::IpBcast) return o;
            if ((mdl_local_ip & mdl_net_mask) == (r.dst_ip & mdl_net_mask)) return o;
            if (r.ip_proto != nct_pkg::ProtoTcp && r.ip_proto != nct_pkg::ProtoUdp) return o;
            hit = -1;
            for (int i = 0; i < Entries; i++)
               if (hit < 0 && tab_sip[i] == r.src_ip && tab_dip[i] == r.dst_ip &&
                   tab_sport[i] == r.src_l4_port && tab_dport[i] == r.dst_l4_port &&
                   tab_proto[i] == r.ip_proto) hit = i;
            if (hit < 0) begin
               best = '0;
               hit = 0;
               for (int i = 0; i < Entries; i++) begin
                  age = r.now_tick - tab_used[i];
                  if (!tab_pin[i] && age > best) begin
                     best = age;
                     hit = i;
                  end
               end
               tab_sip[hit] = r.src_ip;
               tab_dip[hit] = r.dst_ip;
               tab_sport[hit] = r.src_l4_port;
               tab_dport[hit] = r.dst_l4_port;
               tab_proto[hit] = r.ip_proto;
            end
            tab_used[hit] = r.now_tick;
            o = '{1'b0, mdl_local_ip, mdl_divert, 5'(hit)};
         end
         nct_pkg::CMD_INBOUND: begin
            if (r.ether_type != nct_pkg::EthIpv4) return o;
            if (r.src_ip != mdl_local_ip && r.src_l4_port != mdl_divert) return o;
            if (r.ip_proto != nct_pkg::ProtoTcp && r.ip_proto != nct_pkg::ProtoUdp &&
                r.ip_proto != nct_pkg::ProtoIcmp) return o;
            hit = find_src(r.dst_ip, r.dst_l4_port, r.ip_proto);
            if (hit < 0) return o;
            o = '{1'b0, tab_dip[hit], tab_dport[hit], 5'(hit)};
         end
         nct_pkg::CMD_PIN: begin
            hit = find_src(r.src_ip, r.src_l4_port, r.ip_proto);
            if (hit < 0) return o;
            tab_pin[hit] = 1'b1;
            o = '{1'b0, tab_dip[hit], tab_dport[hit], 5'(hit)};
         end
         default: begin
            tab_pin[r.entry_sel] = 1'b0;
            o = '{1'b0, 32'd0, 16'd0, r.entry_sel};
         end
      endcase
      return o;
   endfunction

   // Send one request transaction after a random gap
   task automatic send_packet(nct_pkg::req_type r);
      int gap;
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(predict_translation(r));
      if (r.command == nct_pkg::CMD_OUTBOUND) flow_pool.push_back(r);
      if (flow_pool.size() > 24) void'(flow_pool.pop_front());
   endtask

   // Write one register, mirroring it into the model; only while idle
   task automatic write_reg(nct_pkg::reg_type idx, logic [31:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         nct_pkg::REG_LOCAL_IP: mdl_local_ip = val;
         nct_pkg::REG_NET_MASK: mdl_net_mask = val;
         default: mdl_divert = val[15:0];
      endcase
      @(posedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // Receiver: random stall per response, compare with the oldest prediction
   initial begin
      int stall;
      nct_pkg::rsp_type exp_rsp;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 8);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_rsp.size() == 0) begin
            $error("response with no expectation waiting");
            errors++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.verdict !== exp_rsp.verdict) begin
               $error("verdict expected %0h actual %0h", exp_rsp.verdict, rsp_data.verdict);
               errors++;
            end
            if (rsp_data.new_ip !== exp_rsp.new_ip) begin
               $error("new_ip expected %0h actual %0h", exp_rsp.new_ip, rsp_data.new_ip);
               errors++;
            end
            if (rsp_data.new_port !== exp_rsp.new_port) begin
               $error("new_port expected %0h actual %0h", exp_rsp.new_port,
                      rsp_data.new_port);
               errors++;
            end
            if (rsp_data.entry_index !== exp_rsp.entry_index) begin
               $error("entry_index expected %0h actual %0h", exp_rsp.entry_index,
                      rsp_data.entry_index);
               errors++;
            end
         end
      end
   end

   // Watchdog: count cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic nct_pkg::req_type rand_header();
      nct_pkg::req_type r;
      r.command = 2'($urandom);
      r.ether_type = ($urandom_range(0, 4) == 0) ? 16'($urandom) : nct_pkg::EthIpv4;
      case ($urandom_range(0, 4))
         0: r.ip_proto = nct_pkg::ProtoTcp;
         1: r.ip_proto = nct_pkg::ProtoUdp;
         2: r.ip_proto = nct_pkg::ProtoIcmp;
         3: r.ip_proto = 8'($urandom);
         default: r.ip_proto = nct_pkg::ProtoTcp;
      endcase
      r.src_ip = $urandom;
      r.dst_ip = ($urandom_range(0, 15) == 0) ? nct_pkg::IpBcast : $urandom;
      r.src_l4_port = 16'($urandom);
      r.dst_l4_port = 16'($urandom);
      r.now_tick = $urandom;
      r.entry_sel = 5'($urandom);
      return r;
   endfunction

   // Build a request that refers to a known flow
   function automatic nct_pkg::req_type flow_header(nct_pkg::cmd_type c, logic [31:0] tick);
      nct_pkg::req_type r, f;
      r = rand_header();
      r.command = c;
      r.now_tick = tick;
      if (flow_pool.size() == 0) return r;
      f = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
      r.ip_proto = f.ip_proto;
      r.ether_type = nct_pkg::EthIpv4;
      case (c)
         nct_pkg::CMD_OUTBOUND: begin
            r.src_ip = f.src_ip; r.dst_ip = f.dst_ip;
            r.src_l4_port = f.src_l4_port; r.dst_l4_port = f.dst_l4_port;
         end
         nct_pkg::CMD_INBOUND: begin
            r.dst_ip = f.src_ip; r.dst_l4_port = f.src_l4_port;
            if ($urandom_range(0, 1)) r.src_ip = mdl_local_ip;
            else r.src_l4_port = mdl_divert;
         end
         nct_pkg::CMD_PIN: begin
            r.src_ip = f.src_ip; r.src_l4_port = f.src_l4_port;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic test_directed();
      nct_pkg::req_type r;
      // inbound miss on empty table, all-zero entry matches and pin of it
      r = '0; r.command = nct_pkg::CMD_INBOUND; r.ether_type = nct_pkg::EthIpv4;
      r.ip_proto = nct_pkg::ProtoIcmp;
      send_packet(r);
      r = '0; r.command = nct_pkg::CMD_PIN; send_packet(r);
      // outbound gate: wrong ethertype, broadcast, local subnet, bad protocol
      r = '0; r.command = nct_pkg::CMD_OUTBOUND; r.ether_type = 16'hFFFF;
      r.ip_proto = nct_pkg::ProtoTcp;
      r.dst_ip = 32'h0A000001; send_packet(r);
      r.ether_type = nct_pkg::EthIpv4; r.dst_ip = nct_pkg::IpBcast; send_packet(r);
      r.dst_ip = 32'h0000_0055; send_packet(r);
      r.dst_ip = 32'h0A000001; r.ip_proto = nct_pkg::ProtoIcmp; send_packet(r);
      // outbound misses with extreme fields, then a hit
      r.ip_proto = nct_pkg::ProtoUdp; r.src_ip = '1; r.src_l4_port = '1;
      r.dst_l4_port = '1;
      r.now_tick = '1; send_packet(r);
      r.ip_proto = nct_pkg::ProtoTcp; r.src_ip = 32'h1; r.now_tick = 32'd5; send_packet(r);
      r.now_tick = 32'd0; send_packet(r);
      // inbound via port, via ip, and with neither
      r = '0; r.command = nct_pkg::CMD_INBOUND; r.ether_type = nct_pkg::EthIpv4;
      r.ip_proto = nct_pkg::ProtoTcp;
      r.dst_ip = 32'h1; r.src_l4_port = mdl_divert; r.src_ip = 32'hDEAD; send_packet(r);
      r.src_l4_port = 16'h0; r.src_ip = mdl_local_ip; send_packet(r);
      r.src_ip = 32'hDEAD; r.src_l4_port = 16'h7; send_packet(r);
      // unpin at both ends of the table
      r = '0; r.command = nct_pkg::CMD_UNPIN; r.entry_sel = 5'd0; send_packet(r);
      r.entry_sel = 5'd31; r.src_ip = '1; r.dst_ip = '1; r.now_tick = '1;
      r.ether_type = '1; r.ip_proto = '1; r.src_l4_port = '1; r.dst_l4_port = '1;
      send_packet(r);
      drain_responses();
   endtask

   task automatic test_random_traffic(int count);
      logic [31:0] tick;
      int pick;
      tick = $urandom;
      for (int n = 0; n < count; n++) begin
         tick = tick + $urandom_range(0, 3);
         pick = $urandom_range(0, 9);
         if (pick < 4) send_packet(flow_header(nct_pkg::CMD_OUTBOUND, tick));
         else if (pick < 6) send_packet(flow_header(nct_pkg::CMD_INBOUND, tick));
         else if (pick < 7) send_packet(flow_header(nct_pkg::CMD_PIN, tick));
         else if (pick < 8) send_packet(flow_header(nct_pkg::CMD_UNPIN, tick));
         else send_packet(rand_header());
      end
      drain_responses();
   endtask

   initial begin
      mdl_local_ip = nct_pkg::RstLocalIp;
      mdl_net_mask = nct_pkg::RstNetMask;
      mdl_divert = nct_pkg::RstDivert;
      for (int i = 0; i < Entries; i++) begin
         tab_sip[i] = '0; tab_dip[i] = '0; tab_sport[i] = '0; tab_dport[i] = '0;
         tab_proto[i] = '0; tab_used[i] = '0; tab_pin[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_traffic(110);
      write_reg(nct_pkg::REG_LOCAL_IP, 32'hC0A8_0001);
      write_reg(nct_pkg::REG_NET_MASK, 32'hFFFF_0000);
      write_reg(nct_pkg::REG_DIVERT_PORT, 32'h0000_FFFF);
      test_random_traffic(110);
      write_reg(nct_pkg::REG_LOCAL_IP, 32'hFFFF_FFFF);
      write_reg(nct_pkg::REG_NET_MASK, 32'h0);
      write_reg(nct_pkg::REG_DIVERT_PORT, 32'h0);
      test_random_traffic(60);
      write_reg(nct_pkg::REG_LOCAL_IP, $urandom);
      write_reg(nct_pkg::REG_NET_MASK, 32'hFFFF_FFFF);
      write_reg(nct_pkg::REG_DIVERT_PORT, $urandom);
      test_random_traffic(150);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// File: sim.f
+incdir+rtl
rtl/nct_pkg.sv
rtl/nct_cell.sv
rtl/nct_seq.sv
rtl/nat_connection_table_top.sv
tb/sv/nat_connection_table_top_test.sv
